// File: design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("same-cycle implication violated");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("next-cycle implication violated");

`endif

// File: design/itap_pkg.sv
package itap_pkg;

	// apb address map: one register, word aligned
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_IDX_FAMILY = 1'b0;

	localparam logic FAM_V4 = 1'b0;
	localparam logic FAM_V6 = 1'b1;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	localparam logic [3:0]  MAX_GROUPS     = 4'd8;
	localparam logic [3:0]  MAX_QUAD_LEAD  = 4'd6;
	localparam logic [2:0]  MAX_OCTETS     = 3'd4;
	localparam logic [2:0]  MAX_HEX_DIGITS = 3'd4;
	localparam logic [11:0] OCTET_MAX      = 12'd255;
	localparam logic [8:0]  DEC_SAT        = 9'd256;

	typedef enum logic [1:0] {
		SP_FIRST,
		SP_COLON,
		SP_RUN
	} start_phase_t;

	typedef enum logic {
		PP_GROUPS,
		PP_QUAD
	} parse_phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_digit_t;

	// group 0 and octet 0 sit in the most significant bits
	typedef struct packed {
		start_phase_t        start_phase;
		parse_phase_t        parse_phase;
		logic                error_seen;
		logic                text_ended;
		logic [15:0]         hex_value;
		logic [2:0]          hex_digit_count;
		logic [8:0]          token_decimal;
		logic                token_is_decimal;
		logic [0:7][15:0]    groups;
		logic [3:0]          group_count;
		logic                gap_seen;
		logic [3:0]          gap_position;
		logic [0:3][7:0]     octets;
		logic [2:0]          octet_count;
		logic                digit_in_octet;
		logic                colon_after_group;
	} parse_state_t;

	localparam parse_state_t STATE_CLEAR = '{
		start_phase:       SP_FIRST,
		parse_phase:       PP_GROUPS,
		error_seen:        1'b0,
		text_ended:        1'b0,
		hex_value:         16'd0,
		hex_digit_count:   3'd0,
		token_decimal:     9'd0,
		token_is_decimal:  1'b1,
		groups:            '0,
		group_count:       4'd0,
		gap_seen:          1'b0,
		gap_position:      4'd0,
		octets:            '0,
		octet_count:       3'd0,
		digit_in_octet:    1'b0,
		colon_after_group: 1'b0
	};

	function automatic hex_digit_t hex_of(logic [7:0] c);
		hex_digit_t h;
		h.ok  = 1'b1;
		h.val = c[3:0];
		if (c inside {[CH_0:CH_9]}) begin
			h.val = c[3:0];
		end else if (c inside {[CH_LA:CH_LF], [CH_UA:CH_UF]}) begin
			h.val = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

// File: design/ip_text_address_parser.sv
// ip address text parser, ipv4 dotted quad or ipv6 colon-hex, one character per transfer
// a character passes the input register and then the result register on its way to the output ports
// throughput: one character per cycle, sustained, while the output is not stalled
// only the last character of a text makes a result; all others complete without output
// reset (arst_n low, asynchronous): family = ipv4, parse state cleared, no result pending
`include "assert_macros.svh"

module ip_text_address_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	// character channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    text_char,
	input  logic                          last,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          valid_res,
	output logic [63:0]                   address_high,
	output logic [63:0]                   address_low,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [itap_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// ------------------------------------------------------------------
	// per-character update helpers
	// ------------------------------------------------------------------

	// decimal octet digits and dots of a dotted quad
	function automatic itap_pkg::parse_state_t quad_step(itap_pkg::parse_state_t s,
			logic [7:0] c);
		itap_pkg::parse_state_t r;
		logic [1:0]  idx;
		logic [7:0]  base;
		logic [11:0] nv;
		r    = s;
		idx  = '0;
		base = '0;
		nv   = '0;
		if (c inside {[itap_pkg::CH_0:itap_pkg::CH_9]}) begin
			if (!s.digit_in_octet && s.octet_count >= itap_pkg::MAX_OCTETS) begin
				r.error_seen = 1'b1;
			end else begin
				if (!s.digit_in_octet) begin
					idx              = s.octet_count[1:0];
					base             = 8'd0;
					r.octet_count    = s.octet_count + 3'd1;
					r.digit_in_octet = 1'b1;
				end else begin
					idx  = s.octet_count[1:0] - 2'd1;
					base = s.octets[idx];
				end
				nv = {4'd0, base} * 12'd10 + {8'd0, c[3:0]};
				if (nv > itap_pkg::OCTET_MAX) begin
					r.error_seen = 1'b1;
				end else begin
					r.octets[idx] = nv[7:0];
				end
			end
		end else if (c == itap_pkg::CH_DOT && s.digit_in_octet) begin
			if (s.octet_count >= itap_pkg::MAX_OCTETS) begin
				r.error_seen = 1'b1;
			end else begin
				r.digit_in_octet = 1'b0;
			end
		end else begin
			r.error_seen = 1'b1;
		end
		return r;
	endfunction

	// hex groups, the gap and the switch into an embedded quad
	function automatic itap_pkg::parse_state_t hex_step(itap_pkg::parse_state_t s,
			logic [7:0] c);
		itap_pkg::parse_state_t r;
		itap_pkg::hex_digit_t   h;
		logic [11:0]            d;
		r = s;
		h = itap_pkg::hex_of(c);
		d = '0;
		r.colon_after_group = 1'b0;
		if (h.ok) begin
			if (s.hex_digit_count >= itap_pkg::MAX_HEX_DIGITS) begin
				r.error_seen = 1'b1;
			end else begin
				r.hex_value       = {s.hex_value[11:0], h.val};
				r.hex_digit_count = s.hex_digit_count + 3'd1;
				if (c inside {[itap_pkg::CH_0:itap_pkg::CH_9]}) begin
					d = {3'd0, s.token_decimal} * 12'd10 + {8'd0, c[3:0]};
					r.token_decimal = (d > {3'd0, itap_pkg::DEC_SAT}) ?
						itap_pkg::DEC_SAT : d[8:0];
				end else begin
					r.token_is_decimal = 1'b0;
				end
			end
		end else if (c == itap_pkg::CH_COLON) begin
			if (s.hex_digit_count == 3'd0) begin
				if (s.gap_seen) begin
					r.error_seen = 1'b1;
				end else begin
					r.gap_seen     = 1'b1;
					r.gap_position = s.group_count;
				end
			end else if (s.group_count >= itap_pkg::MAX_GROUPS) begin
				r.error_seen = 1'b1;
			end else begin
				r.groups[s.group_count[2:0]] = s.hex_value;
				r.group_count       = s.group_count + 4'd1;
				r.hex_value         = 16'd0;
				r.hex_digit_count   = 3'd0;
				r.token_decimal     = 9'd0;
				r.token_is_decimal  = 1'b1;
				r.colon_after_group = 1'b1;
			end
		end else if (c == itap_pkg::CH_DOT && s.group_count <= itap_pkg::MAX_QUAD_LEAD &&
				s.hex_digit_count != 3'd0 && s.token_is_decimal &&
				s.token_decimal <= itap_pkg::OCTET_MAX[8:0]) begin
			r.octets           = '0;
			r.octets[0]        = s.token_decimal[7:0];
			r.octet_count      = 3'd1;
			r.digit_in_octet   = 1'b0;
			r.parse_phase      = itap_pkg::PP_QUAD;
			r.hex_value        = 16'd0;
			r.hex_digit_count  = 3'd0;
			r.token_decimal    = 9'd0;
			r.token_is_decimal = 1'b1;
		end else begin
			r.error_seen = 1'b1;
		end
		return r;
	endfunction

	// one character under the family currently set
	function automatic itap_pkg::parse_state_t char_step(itap_pkg::parse_state_t s,
			logic [7:0] c, logic fam);
		itap_pkg::parse_state_t r;
		logic                   consumed;
		r        = s;
		consumed = 1'b0;
		if (!s.error_seen && !s.text_ended) begin
			if (c == itap_pkg::CH_NUL) begin
				r.text_ended = 1'b1;
			end else if (fam == itap_pkg::FAM_V4) begin
				r = quad_step(s, c);
			end else begin
				if (s.start_phase == itap_pkg::SP_FIRST) begin
					if (c == itap_pkg::CH_COLON) begin
						r.start_phase = itap_pkg::SP_COLON;
						consumed      = 1'b1;
					end else begin
						r.start_phase = itap_pkg::SP_RUN;
					end
				end else if (s.start_phase == itap_pkg::SP_COLON) begin
					// a leading colon must be the start of a double colon
					if (c != itap_pkg::CH_COLON) begin
						r.error_seen = 1'b1;
						consumed     = 1'b1;
					end
					r.start_phase = itap_pkg::SP_RUN;
				end
				if (!consumed) begin
					if (r.parse_phase == itap_pkg::PP_QUAD) begin
						r = quad_step(r, c);
					end else begin
						r = hex_step(r, c);
					end
				end
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// configuration register
	// ------------------------------------------------------------------
	logic family_q;
	logic cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready &&
		paddr[2] == itap_pkg::REG_IDX_FAMILY;
	// only the family register is mapped, everything else reads as zero
	assign prdata    = (paddr[2] == itap_pkg::REG_IDX_FAMILY) ? {31'd0, family_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			family_q <= itap_pkg::FAM_V4;
		end else if (cfg_write) begin
			family_q <= pwdata[0];
		end
	end

	// ------------------------------------------------------------------
	// input register and flow control
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic       out_free;
	logic       advance_s1;
	logic       process_s1;
	logic       load_result;

	// the result register can take a new result this cycle
	assign out_free    = !out_valid_q || !out_stall;
	// only a last character needs room in the result register
	assign advance_s1  = !valid_s1 || !last_s1 || out_free;
	assign in_stall    = !advance_s1;
	assign process_s1  = valid_s1 && advance_s1;
	assign load_result = process_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the input register, no reset
	always_ff @(posedge clk) begin
		if (in_valid && advance_s1) begin
			char_s1 <= text_char;
			last_s1 <= last;
		end
	end

	// ------------------------------------------------------------------
	// parse state update
	// ------------------------------------------------------------------
	itap_pkg::parse_state_t st_q;
	itap_pkg::parse_state_t st_n;

	assign st_n = char_step(st_q, char_s1, family_q);

	// the last character hands off its result and starts a fresh text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= itap_pkg::STATE_CLEAR;
		end else if (process_s1) begin
			st_q <= last_s1 ? itap_pkg::STATE_CLEAR : st_n;
		end
	end

	// ------------------------------------------------------------------
	// end-of-text assembly, from the state after the last character
	// ------------------------------------------------------------------
	logic         v4_ok;
	logic         v6_ok;
	logic [3:0]   word_count;
	logic [3:0]   gap_words;
	logic [31:0]  token_bits;
	logic [127:0] keep_groups;
	logic [127:0] packed_words;
	logic [127:0] head_mask;
	logic [127:0] gap_filled;
	logic [127:0] v6_bytes;
	logic         res_ok;
	logic [63:0]  res_high;
	logic [63:0]  res_low;

	assign v4_ok = !st_n.error_seen && st_n.octet_count == itap_pkg::MAX_OCTETS;

	// the open token or the embedded quad follows the stored groups
	always_comb begin
		v6_ok      = !st_n.error_seen && st_n.start_phase != itap_pkg::SP_COLON &&
			!st_n.colon_after_group && st_n.group_count <= itap_pkg::MAX_GROUPS;
		word_count = st_n.group_count;
		token_bits = 32'd0;
		if (st_n.parse_phase == itap_pkg::PP_QUAD) begin
			token_bits = st_n.octets;
			word_count = st_n.group_count + 4'd2;
			if (st_n.octet_count < itap_pkg::MAX_OCTETS || word_count > itap_pkg::MAX_GROUPS) begin
				v6_ok = 1'b0;
			end
		end else if (st_n.hex_digit_count != 3'd0) begin
			token_bits = {st_n.hex_value, 16'd0};
			word_count = st_n.group_count + 4'd1;
			if (st_n.group_count >= itap_pkg::MAX_GROUPS) begin
				v6_ok = 1'b0;
			end
		end
		// a gap needs at least one zero group, without a gap all eight are given
		if (st_n.gap_seen) begin
			if (word_count == itap_pkg::MAX_GROUPS) begin
				v6_ok = 1'b0;
			end
		end else if (word_count != itap_pkg::MAX_GROUPS) begin
			v6_ok = 1'b0;
		end
	end

	assign keep_groups  = ~({128{1'b1}} >> {st_n.group_count, 4'd0});
	assign packed_words = (st_n.groups & keep_groups) |
		({token_bits, 96'd0} >> {st_n.group_count, 4'd0});

	// words before the gap stay, the rest slide down to the end of the address
	assign gap_words  = (st_n.gap_position > word_count) ? word_count : st_n.gap_position;
	assign head_mask  = ~({128{1'b1}} >> {gap_words, 4'd0});
	assign gap_filled = (packed_words & head_mask) |
		((packed_words & ~head_mask) >> {itap_pkg::MAX_GROUPS - word_count, 4'd0});
	assign v6_bytes   = st_n.gap_seen ? gap_filled : packed_words;

	always_comb begin
		if (family_q == itap_pkg::FAM_V4) begin
			res_ok   = v4_ok;
			res_high = 64'd0;
			res_low  = v4_ok ? {32'd0, st_n.octets} : 64'd0;
		end else begin
			res_ok   = v6_ok;
			res_high = v6_ok ? v6_bytes[127:64] : 64'd0;
			res_low  = v6_ok ? v6_bytes[63:0] : 64'd0;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	logic        valid_res_q;
	logic [63:0] address_high_q;
	logic [63:0] address_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			valid_res_q    <= res_ok;
			address_high_q <= res_high;
			address_low_q  <= res_low;
		end
	end

	assign out_valid    = out_valid_q;
	assign valid_res    = valid_res_q;
	assign address_high = address_high_q;
	assign address_low  = address_low_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// the input side only waits on a last character blocked by a full result register
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, valid_s1 && last_s1 && out_valid_q)
	// a last character that moves on always shows up as a result
	`ASSERT_NEXT(a_result_loaded, clk, arst_n, load_result, out_valid_q)
	// a rejected text never leaks address bits
	`ASSERT_IMPL(a_invalid_zero, clk, arst_n, out_valid_q && !valid_res_q,
		address_high_q == 64'd0 && address_low_q == 64'd0)
	// the group counter never runs past a full address
	`ASSERT_IMPL(a_group_bound, clk, arst_n, valid_s1, st_q.group_count <= itap_pkg::MAX_GROUPS)

endmodule

// File: verif/ip_text_address_parser_test.sv
module ip_text_address_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	// one address result as it leaves the block
	typedef struct packed {
		logic        ok;
		logic [63:0] hi;
		logic [63:0] lo;
	} addr_result_t;

	// one directed text: family, characters ('#' stands for a nul), the index at which
	// the family flips mid-text (-1 for none), and a typed result where fixed is set
	typedef struct {
		bit          v6;
		string       text;
		int          flip_at;
		bit          fixed;
		bit          ok;
		logic [63:0] hi;
		logic [63:0] lo;
	} text_case_t;

	localparam logic [7:0] NUL_MARK = "#";
	localparam int DRAIN_CYCLES = 4;     // margin after the last expected result has left
	localparam int HOLD_CYCLES = 300;    // long receiver hold-off under pressure
	localparam int RANDOM_CHARS = 560;
	localparam int DRAIN_GUARD = 20000;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [7:0]                    text_char;
	logic                          last;
	logic                          out_valid;
	logic                          out_stall;
	logic                          valid_res;
	logic [63:0]                   address_high;
	logic [63:0]                   address_low;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [itap_pkg::ADDR_W-1:0]   paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;

	ip_text_address_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_char    (text_char),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.valid_res    (valid_res),
		.address_high (address_high),
		.address_low  (address_low),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// ------------------------------------------------------------------
	// parser mirror: family register plus the per-text parse state
	// ------------------------------------------------------------------
	bit                     family_v6;
	itap_pkg::start_phase_t lead_phase;     // first char, after one leading colon, running
	itap_pkg::parse_phase_t body_phase;     // hex groups or embedded dotted quad
	bit           text_bad;
	bit           text_done;      // nul seen, rest of the text ignored
	logic [15:0]  hex_acc;
	int           hex_digits;
	int           dec_acc;        // decimal view of the token, saturates at 256
	bit           dec_only;
	logic [15:0]  grp_words [8];
	int           grp_count;
	bit           gap_found;
	int           gap_at;
	logic [7:0]   quad_bytes [4];
	int           quad_count;
	bit           in_octet;
	bit           ends_on_colon;

	addr_result_t expected_addrs [$];

	int error_count;
	int chars_sent;
	int texts_v4;
	int texts_v6;
	int family_writes;
	int results_checked;
	int valid_seen;

	bit tx_calm;
	bit rx_calm;
	bit hold_req;

	function automatic void clear_token();
		hex_acc = '0;
		hex_digits = 0;
		dec_acc = 0;
		dec_only = 1'b1;
	endfunction

	function automatic void clear_text();
		lead_phase = itap_pkg::SP_FIRST;
		body_phase = itap_pkg::PP_GROUPS;
		text_bad = 1'b0;
		text_done = 1'b0;
		clear_token();
		foreach (grp_words[i]) grp_words[i] = '0;
		grp_count = 0;
		gap_found = 1'b0;
		gap_at = 0;
		foreach (quad_bytes[i]) quad_bytes[i] = '0;
		quad_count = 0;
		in_octet = 1'b0;
		ends_on_colon = 1'b0;
	endfunction

	function automatic int digit_value(logic [7:0] c);
		if (c >= itap_pkg::CH_0 && c <= itap_pkg::CH_9)
			return int'(c) - int'(itap_pkg::CH_0);
		if (c >= itap_pkg::CH_LA && c <= itap_pkg::CH_LF)
			return int'(c) - int'(itap_pkg::CH_LA) + 10;
		if (c >= itap_pkg::CH_UA && c <= itap_pkg::CH_UF)
			return int'(c) - int'(itap_pkg::CH_UA) + 10;
		return -1;
	endfunction

	// dotted quad character, used by ipv4 and by the ipv6 tail
	function automatic void take_quad_char(logic [7:0] c);
		int idx;
		int nv;
		if (c >= itap_pkg::CH_0 && c <= itap_pkg::CH_9) begin
			if (!in_octet) begin
				if (quad_count >= 4) begin
					text_bad = 1'b1;
					return;
				end
				quad_bytes[quad_count & 3] = '0;
				quad_count++;
				in_octet = 1'b1;
			end
			idx = (quad_count - 1) & 3;
			nv = int'(quad_bytes[idx]) * 10 + (int'(c) - int'(itap_pkg::CH_0));
			if (nv > 255) begin
				text_bad = 1'b1;
				return;
			end
			quad_bytes[idx] = nv[7:0];
		end else if (c == itap_pkg::CH_DOT && in_octet) begin
			if (quad_count >= 4) begin
				text_bad = 1'b1;
				return;
			end
			in_octet = 1'b0;
		end else begin
			text_bad = 1'b1;
		end
	endfunction

	// colon-hex character
	function automatic void take_hex_char(logic [7:0] c);
		int x;
		int d;
		x = digit_value(c);
		ends_on_colon = 1'b0;
		if (x >= 0) begin
			if (hex_digits >= 4) begin
				text_bad = 1'b1;
				return;
			end
			hex_acc = {hex_acc[11:0], 4'(x)};
			hex_digits++;
			if (c >= itap_pkg::CH_0 && c <= itap_pkg::CH_9) begin
				d = dec_acc * 10 + x;
				dec_acc = (d > 255) ? 256 : d;
			end else begin
				dec_only = 1'b0;
			end
			return;
		end
		if (c == itap_pkg::CH_COLON) begin
			if (hex_digits == 0) begin
				if (gap_found) begin
					text_bad = 1'b1;
					return;
				end
				gap_found = 1'b1;
				gap_at = grp_count;
				return;
			end
			if (grp_count >= 8) begin
				text_bad = 1'b1;
				return;
			end
			grp_words[grp_count & 7] = hex_acc;
			grp_count++;
			clear_token();
			ends_on_colon = 1'b1;
			return;
		end
		// a dot turns a short decimal token into the first octet of a quad
		if (c == itap_pkg::CH_DOT && grp_count <= 6 && hex_digits > 0 && dec_only &&
				dec_acc <= 255) begin
			foreach (quad_bytes[i]) quad_bytes[i] = '0;
			quad_bytes[0] = dec_acc[7:0];
			quad_count = 1;
			in_octet = 1'b0;
			body_phase = itap_pkg::PP_QUAD;
			clear_token();
			return;
		end
		text_bad = 1'b1;
	endfunction

	// lay out the ipv6 bytes, expanding the gap; returns 0 if the text is not an address
	function automatic bit assemble_v6(output logic [127:0] a);
		logic [7:0] tmp [16];
		int n;
		int gp;
		int tail;
		a = '0;
		if (text_bad || lead_phase == itap_pkg::SP_COLON || ends_on_colon) return 1'b0;
		foreach (tmp[i]) tmp[i] = '0;
		if (grp_count > 8) return 1'b0;
		for (int i = 0; i < grp_count; i++) begin
			tmp[2 * i] = grp_words[i][15:8];
			tmp[2 * i + 1] = grp_words[i][7:0];
		end
		n = 2 * grp_count;
		if (body_phase == itap_pkg::PP_QUAD) begin
			if (quad_count < 4 || n + 4 > 16) return 1'b0;
			for (int i = 0; i < 4; i++) tmp[n + i] = quad_bytes[i];
			n += 4;
		end else if (hex_digits > 0) begin
			if (grp_count >= 8) return 1'b0;
			tmp[n] = hex_acc[15:8];
			tmp[n + 1] = hex_acc[7:0];
			n += 2;
		end
		if (gap_found) begin
			if (n == 16) return 1'b0;
			gp = (2 * gap_at > n) ? n : 2 * gap_at;
			tail = n - gp;
			for (int i = 0; i < 16; i++) begin
				if (i < gp) a = {a[119:0], tmp[i]};
				else if (i >= 16 - tail) a = {a[119:0], tmp[i - (16 - tail) + gp]};
				else a = {a[119:0], 8'h00};
			end
			return 1'b1;
		end
		if (n != 16) return 1'b0;
		for (int i = 0; i < 16; i++) a = {a[119:0], tmp[i]};
		return 1'b1;
	endfunction

	// advance the mirror by one character; returns 1 when the character makes a result
	function automatic bit parse_char(logic [7:0] c, logic lst, output addr_result_t r);
		bit skip;
		logic [127:0] a;
		r = '0;
		if (!text_bad && !text_done) begin
			if (c == itap_pkg::CH_NUL) begin
				text_done = 1'b1;
			end else if (!family_v6) begin
				take_quad_char(c);
			end else begin
				skip = 1'b0;
				// a leading colon must be followed by a second one
				if (lead_phase == itap_pkg::SP_FIRST) begin
					if (c == itap_pkg::CH_COLON) begin
						lead_phase = itap_pkg::SP_COLON;
						skip = 1'b1;
					end else begin
						lead_phase = itap_pkg::SP_RUN;
					end
				end else if (lead_phase == itap_pkg::SP_COLON) begin
					if (c != itap_pkg::CH_COLON) begin
						text_bad = 1'b1;
						skip = 1'b1;
					end
					lead_phase = itap_pkg::SP_RUN;
				end
				if (!skip) begin
					if (body_phase == itap_pkg::PP_QUAD) take_quad_char(c);
					else take_hex_char(c);
				end
			end
		end
		if (!lst) return 1'b0;
		// the family in force on the last character decides the result
		if (!family_v6) begin
			r.ok = !text_bad && quad_count == 4;
			if (r.ok) r.lo = {32'd0, quad_bytes[0], quad_bytes[1], quad_bytes[2], quad_bytes[3]};
		end else begin
			r.ok = assemble_v6(a);
			if (r.ok) {r.hi, r.lo} = a;
		end
		clear_text();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// clock, time limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous bound, far above the slowest legal run
	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// result side: random stall, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (!rx_calm && r < 15) begin
					out_stall = 1'b1;
					// mostly short stalls, now and then a long one
					stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
						: $urandom_range(10, 35);
				end else begin
					out_stall = 1'b0;
				end
			end
		end
	end

	// result checker: every output transfer against the oldest expectation
	always @(posedge clk) begin
		addr_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_addrs.size() == 0) begin
				$error("result transfer with nothing expected: valid_res=%0b high=%h low=%h",
					valid_res, address_high, address_low);
				error_count++;
			end else begin
				want = expected_addrs.pop_front();
				results_checked++;
				if (want.ok) valid_seen++;
				if (valid_res !== want.ok) begin
					$error("valid_res mismatch: expected %0b, got %0b", want.ok, valid_res);
					error_count++;
				end
				if (address_high !== want.hi) begin
					$error("address_high mismatch: expected %h, got %h", want.hi, address_high);
					error_count++;
				end
				if (address_low !== want.lo) begin
					$error("address_low mismatch: expected %h, got %h", want.lo, address_low);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// character side
	// ------------------------------------------------------------------
	function automatic int idle_gap();
		int r;
		if (tx_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// offer one character, wait for its transfer, then maybe idle a while
	task automatic send_char(logic [7:0] c, logic lst, bit use_fixed, addr_result_t fixed);
		addr_result_t r;
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		text_char = c;
		last = lst;
		do @(posedge clk); while (in_stall);
		if (parse_char(c, lst, r)) begin
			expected_addrs.push_back(use_fixed ? fixed : r);
			if (family_v6) texts_v6++;
			else texts_v4++;
		end
		chars_sent++;
		gap = idle_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stop offering, let every expected result out, then give the pipe time to settle
	task automatic drain_results();
		int guard;
		guard = 0;
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_addrs.size() != 0 && guard < DRAIN_GUARD) begin
			@(negedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// apb write of the family register, then read it back
	task automatic write_family(bit v6);
		logic [31:0] rd;
		drain_results();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = itap_pkg::ADDR_W'(4 * int'(itap_pkg::REG_IDX_FAMILY));
		pwdata = {31'd0, v6 ? itap_pkg::FAM_V6 : itap_pkg::FAM_V4};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		family_v6 = v6;
		family_writes++;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		if (rd[0] !== (v6 ? itap_pkg::FAM_V6 : itap_pkg::FAM_V4)) begin
			$error("address_family readback mismatch: expected %0b, got %0b", v6, rd[0]);
			error_count++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// random text builders
	// ------------------------------------------------------------------
	function automatic void push_octet(ref logic [7:0] q [$]);
		int v;
		v = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 255) : $urandom_range(256, 999);
		if ($urandom_range(0, 7) == 0) q.push_back(itap_pkg::CH_0);    // leading zero
		if (v >= 100) q.push_back(itap_pkg::CH_0 + 8'(v / 100));
		if (v >= 10) q.push_back(itap_pkg::CH_0 + 8'((v / 10) % 10));
		q.push_back(itap_pkg::CH_0 + 8'(v % 10));
	endfunction

	function automatic void push_hex_group(ref logic [7:0] q [$]);
		int d;
		repeat ($urandom_range(1, 4)) begin
			d = $urandom_range(0, 15);
			if (d < 10) q.push_back(itap_pkg::CH_0 + 8'(d));
			else q.push_back(($urandom_range(0, 1) ? itap_pkg::CH_LA : itap_pkg::CH_UA) +
				8'(d - 10));
		end
	endfunction

	// mostly well-formed text of the given family, some of it broken, some pure noise
	function automatic void make_text(bit v6, ref logic [7:0] q [$]);
		bit quad;
		bit gap;
		int n;
		int at;
		int pos;
		int r;
		q.delete();
		if ($urandom_range(0, 99) < 12) begin
			repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if (!v6) begin
			for (int i = 0; i < 4; i++) begin
				if (i > 0) q.push_back(itap_pkg::CH_DOT);
				push_octet(q);
			end
		end else begin
			quad = ($urandom_range(0, 3) == 0);
			gap = 1'($urandom_range(0, 1));
			n = quad ? 6 : 8;
			at = -1;
			if (gap) begin
				n = $urandom_range(0, n - 1);
				at = $urandom_range(0, n);
			end
			if (gap && at == 0) begin
				q.push_back(itap_pkg::CH_COLON);
				q.push_back(itap_pkg::CH_COLON);
			end
			for (int i = 0; i < n; i++) begin
				if (i > 0) begin
					q.push_back(itap_pkg::CH_COLON);
					if (gap && at == i) q.push_back(itap_pkg::CH_COLON);
				end
				push_hex_group(q);
			end
			if (gap && at == n && n > 0) begin
				q.push_back(itap_pkg::CH_COLON);
				q.push_back(itap_pkg::CH_COLON);
			end
			if (quad) begin
				if (!(gap && at == n)) q.push_back(itap_pkg::CH_COLON);
				for (int i = 0; i < 4; i++) begin
					if (i > 0) q.push_back(itap_pkg::CH_DOT);
					push_octet(q);
				end
			end
		end
		// damage some of the texts
		pos = $urandom_range(0, q.size() - 1);
		r = $urandom_range(0, 99);
		if (r < 55) begin
		end else if (r < 65) begin
			q[pos] = 8'($urandom_range(0, 255));
		end else if (r < 73) begin
			q[pos] = ($urandom_range(0, 1)) ? itap_pkg::CH_COLON : itap_pkg::CH_DOT;
		end else if (r < 80) begin
			if (q.size() > 1) q.delete(pos);
		end else if (r < 87) begin
			q.insert(pos, ($urandom_range(0, 1)) ? itap_pkg::CH_COLON : itap_pkg::CH_DOT);
		end else if (r < 93) begin
			while (q.size() > pos + 1) void'(q.pop_back());
		end else begin
			// early end with junk behind it
			q.insert(pos, itap_pkg::CH_NUL);
			repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// ------------------------------------------------------------------
	// directed texts
	// ------------------------------------------------------------------
	text_case_t dir_cases [26] = '{
		'{0, "255.255.255.255", -1, 1, 1, 64'd0, 64'h0000_0000_ffff_ffff},
		'{0, "0.0.0.0", -1, 1, 1, 64'd0, 64'd0},
		'{0, "010.001.1.0", -1, 0, 0, 64'd0, 64'd0},
		'{0, "256.1.1.1", -1, 1, 0, 64'd0, 64'd0},
		'{0, "1.2.3", -1, 1, 0, 64'd0, 64'd0},
		'{0, "1.2.3.4.5", -1, 1, 0, 64'd0, 64'd0},
		'{0, "1..2.3", -1, 1, 0, 64'd0, 64'd0},
		'{0, "#", -1, 1, 0, 64'd0, 64'd0},
		'{0, "9.8.7.6#x:", -1, 0, 0, 64'd0, 64'd0},
		'{0, "\377", -1, 1, 0, 64'd0, 64'd0},
		'{0, "12.3", 2, 0, 0, 64'd0, 64'd0},
		'{1, "::", -1, 1, 1, 64'd0, 64'd0},
		'{1, "ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff", -1, 1, 1,
			64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff},
		'{1, "1::", -1, 0, 0, 64'd0, 64'd0},
		'{1, ":1::", -1, 1, 0, 64'd0, 64'd0},
		'{1, "1:2:3:4:5:6:7:", -1, 1, 0, 64'd0, 64'd0},
		'{1, "1::2::3", -1, 1, 0, 64'd0, 64'd0},
		'{1, "::ffff:192.168.0.1", -1, 0, 0, 64'd0, 64'd0},
		'{1, "1:2:3:4:5:6:7:8:9", -1, 1, 0, 64'd0, 64'd0},
		'{1, "1:2:3:4::5:6:7:8", -1, 1, 0, 64'd0, 64'd0},
		'{1, "12345::", -1, 1, 0, 64'd0, 64'd0},
		'{1, "a:b:c:d:e:f:1.2.3.4", -1, 0, 0, 64'd0, 64'd0},
		'{1, "abc.1.2.3", -1, 1, 0, 64'd0, 64'd0},
		'{1, "#", -1, 1, 0, 64'd0, 64'd0},
		'{1, "fe80::1#zz", -1, 0, 0, 64'd0, 64'd0},
		'{1, "ab:1.2.3.4", 3, 0, 0, 64'd0, 64'd0}
	};

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		addr_result_t fixed;
		logic [7:0] txt [$];
		logic [7:0] c;
		int stop_at;

		arst_n = 1'b0;
		in_valid = 1'b0;
		text_char = '0;
		last = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_req = 1'b0;
		error_count = 0;
		chars_sent = 0;
		texts_v4 = 0;
		texts_v6 = 0;
		family_writes = 0;
		results_checked = 0;
		valid_seen = 0;
		family_v6 = 1'b0;
		clear_text();

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed table, family starts at its reset value (ipv4)
		foreach (dir_cases[k]) begin
			if (dir_cases[k].v6 != family_v6) write_family(dir_cases[k].v6);
			fixed = '{dir_cases[k].ok, dir_cases[k].hi, dir_cases[k].lo};
			for (int i = 0; i < dir_cases[k].text.len(); i++) begin
				// family change in the middle of a text, once the pipe is empty
				if (i == dir_cases[k].flip_at) write_family(!family_v6);
				c = dir_cases[k].text[i];
				if (c == NUL_MARK) c = itap_pkg::CH_NUL;
				send_char(c, i == dir_cases[k].text.len() - 1, dir_cases[k].fixed, fixed);
			end
		end

		// random texts, family rewritten now and then
		stop_at = chars_sent + RANDOM_CHARS;
		while (chars_sent < stop_at) begin
			if ($urandom_range(0, 11) == 0) write_family(1'($urandom_range(0, 1)));
			tx_calm = ($urandom_range(0, 4) == 0);
			rx_calm = ($urandom_range(0, 4) == 0);
			make_text(family_v6, txt);
			foreach (txt[i]) send_char(txt[i], i == txt.size() - 1, 1'b0, '0);
		end

		// back pressure: receiver holds off while one-character texts keep coming
		tx_calm = 1'b1;
		rx_calm = 1'b0;
		hold_req = 1'b1;
		repeat (60) send_char(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
		tx_calm = 1'b0;

		// sender pauses until everything is out, then a last burst
		drain_results();
		write_family(!family_v6);
		repeat (4) begin
			make_text(family_v6, txt);
			foreach (txt[i]) send_char(txt[i], i == txt.size() - 1, 1'b0, '0);
		end

		drain_results();
		if (expected_addrs.size() != 0) begin
			$error("%0d expected results never arrived", expected_addrs.size());
			error_count++;
		end

		$display("covered %0d texts (%0d ipv4, %0d ipv6) in %0d characters, %0d family writes",
			texts_v4 + texts_v6, texts_v4, texts_v6, chars_sent, family_writes);
		$display("checked %0d results, %0d of them well-formed addresses",
			results_checked, valid_seen);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
